// File: hw/rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared sizes, codes and transfer structs of the lidar scene classifier.
// ----------------------------------------------------------------------------
package lsc_pkg;

	// Sizing
	localparam int MAX_POINTS = 1024;
	localparam int WINDOW     = 100;

	localparam int RANGE_W = 16;
	localparam int PC_W    = $clog2(MAX_POINTS + 1);
	localparam int SPAN_W  = $clog2(MAX_POINTS);
	localparam int JMP_W   = 10;
	localparam int FAR_W   = 11;
	localparam int DSUM_W  = 27;
	localparam int MEAN_W  = 16;
	localparam int VAL_W   = PC_W;

	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int JSUM_W  = $clog2(((1 << JMP_W) - 1) * WINDOW + 1);
	localparam int VSUM_W  = $clog2((MAX_POINTS - 1) * WINDOW + 1);
	localparam int MSUM_W  = $clog2(((1 << MEAN_W) - 1) * WINDOW + 1);

	localparam logic [JMP_W-1:0]  JUMP_MAX = '1;
	localparam logic [FAR_W-1:0]  FAR_MAX  = '1;
	localparam logic [DSUM_W-1:0] DSUM_MAX = '1;

	// Jump ratio bounds: 1.35 and 0.65, cross-multiplied by 100
	localparam int JUMP_DEN    = 100;
	localparam int JUMP_HI_NUM = 135;
	localparam int JUMP_LO_NUM = 65;
	localparam int JCMP_W      = RANGE_W + 8;

	// Configuration
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int THR_W     = 10;
	localparam int PCT_W     = 7;
	localparam int PCT_SCALE = 100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAR_LIMIT  = 3'd0,
		CFG_JUMP_THR   = 3'd1,
		CFG_INDOOR_PCT = 3'd2,
		CFG_DENSE_IN   = 3'd3,
		CFG_DENSE_OUT  = 3'd4
	} cfg_idx_t;

	localparam logic [RANGE_W-1:0] RST_FAR_LIMIT  = 16'd30000;
	localparam logic [THR_W-1:0]   RST_JUMP_THR   = 10'd5;
	localparam logic [PCT_W-1:0]   RST_INDOOR_PCT = 7'd80;
	localparam logic [RANGE_W-1:0] RST_DENSE_IN   = 16'd5000;
	localparam logic [RANGE_W-1:0] RST_DENSE_OUT  = 16'd7000;

	// Classification compare widths
	localparam int LHS_W  = VSUM_W + PCT_W;
	localparam int IPS_W  = PCT_W + CNT_W;
	localparam int RHS_W  = IPS_W + SPAN_W;
	localparam int VCMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int DCMP_W = (MSUM_W > RANGE_W + CNT_W) ? MSUM_W : RANGE_W + CNT_W;
	localparam int TCMP_W = (JSUM_W > THR_W + CNT_W) ? JSUM_W : THR_W + CNT_W;

	typedef enum logic [1:0] {
		DENS_DENSE   = 2'd0,
		DENS_SPARSE  = 2'd1,
		DENS_UNKNOWN = 2'd2
	} dens_t;

	localparam int CLS_W = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_UPD,
		ST_MUL,
		ST_PROD,
		ST_CLS,
		ST_EMIT
	} state_t;

	// Per-scan summary at the closing sample
	typedef struct packed {
		logic              enough;
		logic [SPAN_W-1:0] span;
		logic [JMP_W-1:0]  jumps;
		logic [VAL_W-1:0]  valid;
		logic [DSUM_W-1:0] dsum;
	} scan_sum_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} win_ctl_t;

	typedef struct packed {
		logic [JSUM_W-1:0] jsum;
		logic [VSUM_W-1:0] vsum;
		logic [MSUM_W-1:0] msum;
		logic [CNT_W-1:0]  scans;
	} win_sum_t;

	typedef struct packed {
		logic [JMP_W-1:0]  jumps;
		logic [VAL_W-1:0]  valid;
		logic [MEAN_W-1:0] mean;
	} hist_t;

endpackage

// File: hw/rtl/lsc_scan_acc.sv
// ----------------------------------------------------------------------------
// lsc_scan_acc
// Per-scan counters: jumps, far readings and clamped distance sum.
// ----------------------------------------------------------------------------
module lsc_scan_acc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [lsc_pkg::RANGE_W-1:0] range_mm,
	input  logic                       scan_end,
	input  logic [lsc_pkg::RANGE_W-1:0] far_limit,
	output lsc_pkg::scan_sum_t         sum
);
	import lsc_pkg::*;

	logic [PC_W-1:0]    pc_q, pc_n;
	logic [RANGE_W-1:0] prior_q;
	logic [JMP_W-1:0]   jmp_q, jmp_n;
	logic [FAR_W-1:0]   far_q, far_n;
	logic [DSUM_W-1:0]  dsum_q, dsum_n;

	logic               take, upd, jump, r_far, p_far;
	logic [RANGE_W-1:0] add;
	logic [DSUM_W:0]    dsum_wide;
	logic [JCMP_W-1:0]  r_scaled, p_hi, p_lo;
	logic [SPAN_W-1:0]  span;

	always_comb begin
		take      = pc_q < PC_W'(MAX_POINTS);
		upd       = take && (pc_q != '0);
		r_scaled  = JCMP_W'(range_mm) * JCMP_W'(JUMP_DEN);
		p_hi      = JCMP_W'(prior_q) * JCMP_W'(JUMP_HI_NUM);
		p_lo      = JCMP_W'(prior_q) * JCMP_W'(JUMP_LO_NUM);
		jump      = (r_scaled > p_hi) || (r_scaled < p_lo);
		r_far     = range_mm > far_limit;
		p_far     = prior_q > far_limit;
		add       = r_far ? far_limit : range_mm;
		dsum_wide = {1'b0, dsum_q} + (DSUM_W+1)'(add);

		pc_n   = take ? pc_q + 1'b1 : pc_q;
		jmp_n  = jmp_q;
		far_n  = far_q;
		dsum_n = dsum_q;
		if (upd) begin
			if (jump && !(p_far && r_far) && jmp_q != JUMP_MAX)
				jmp_n = jmp_q + 1'b1;
			if (r_far && far_q != FAR_MAX)
				far_n = far_q + 1'b1;
			dsum_n = dsum_wide[DSUM_W] ? DSUM_MAX : dsum_wide[DSUM_W-1:0];
		end

		span       = SPAN_W'(pc_n - 1'b1);
		sum.enough = pc_n >= PC_W'(2);
		sum.span   = span;
		sum.jumps  = jmp_n;
		sum.valid  = (VAL_W'(far_n) <= VAL_W'(span)) ? VAL_W'(span) - VAL_W'(far_n) : '0;
		sum.dsum   = dsum_n;
	end

	// Close the scan on scan_end whether or not it produces a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			prior_q <= '0;
			jmp_q   <= '0;
			far_q   <= '0;
			dsum_q  <= '0;
		end else if (accept) begin
			if (scan_end) begin
				pc_q    <= '0;
				prior_q <= '0;
				jmp_q   <= '0;
				far_q   <= '0;
				dsum_q  <= '0;
			end else begin
				pc_q   <= pc_n;
				jmp_q  <= jmp_n;
				far_q  <= far_n;
				dsum_q <= dsum_n;
				if (take)
					prior_q <= range_mm;
			end
		end
	end

endmodule

// File: hw/rtl/lsc_div.sv
// ----------------------------------------------------------------------------
// lsc_div
// Restoring divider, one quotient bit per cycle, for the per-scan mean.
// ----------------------------------------------------------------------------
module lsc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lsc_pkg::DSUM_W-1:0] dividend,
	input  logic [lsc_pkg::SPAN_W-1:0] divisor,
	output logic                       done,
	output logic [lsc_pkg::MEAN_W-1:0] quot
);
	import lsc_pkg::*;

	localparam int DCNT_W = $clog2(DSUM_W);

	logic                busy_q, done_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [DSUM_W-1:0]   a_q;
	logic [SPAN_W-1:0]   rem_q, div_q, rem_n;
	logic [SPAN_W:0]     rem_sh;
	logic                ge;

	always_comb begin
		rem_sh = {rem_q, a_q[DSUM_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_n  = ge ? SPAN_W'(rem_sh - {1'b0, div_q}) : rem_sh[SPAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DSUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out on top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q   <= {a_q[DSUM_W-2:0], ge};
			rem_q <= rem_n;
		end
	end

	assign done = done_q;
	assign quot = a_q[MEAN_W-1:0];

endmodule

// File: hw/rtl/lsc_window.sv
// ----------------------------------------------------------------------------
// lsc_window
// Scan history memory and sliding window sums over the last WINDOW scans.
// ----------------------------------------------------------------------------
module lsc_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsc_pkg::win_ctl_t          ctl,
	input  lsc_pkg::hist_t             entry,
	output lsc_pkg::win_sum_t          sums
);
	import lsc_pkg::*;

	hist_t             hist_mem [WINDOW];
	hist_t             rd_q, old;
	logic [SLOT_W-1:0] slot_q;
	logic [JSUM_W-1:0] jsum_q;
	logic [VSUM_W-1:0] vsum_q;
	logic [MSUM_W-1:0] msum_q;
	logic [CNT_W-1:0]  scans_q;
	logic              full;

	// Slots fill in order, so the slot at hand holds history only once full
	assign full = scans_q == CNT_W'(WINDOW);
	assign old  = full ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.rd)
			rd_q <= hist_mem[slot_q];
		if (ctl.wr)
			hist_mem[slot_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			scans_q <= '0;
			jsum_q  <= '0;
			vsum_q  <= '0;
			msum_q  <= '0;
		end else if (ctl.wr) begin
			jsum_q <= jsum_q - JSUM_W'(old.jumps) + JSUM_W'(entry.jumps);
			vsum_q <= vsum_q - VSUM_W'(old.valid) + VSUM_W'(entry.valid);
			msum_q <= msum_q - MSUM_W'(old.mean) + MSUM_W'(entry.mean);
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (!full)
				scans_q <= scans_q + 1'b1;
		end
	end

	assign sums.jsum  = jsum_q;
	assign sums.vsum  = vsum_q;
	assign sums.msum  = msum_q;
	assign sums.scans = scans_q;

endmodule

// File: hw/rtl/lidar_scene_classifier_unit.sv
// ----------------------------------------------------------------------------
// lidar_scene_classifier_unit
// Classifies the scene as indoor/outdoor, features and density from a stream
// of lidar range samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_stall, one transaction per cycle while a
//   scan is streaming; scan_end marks the last sample of a scan.
//   A scan of two or more samples yields one result transaction on
//   out_valid/out_stall; shorter scans are dropped silently.
//   After the closing sample of a scan that yields a result, the block
//   stalls its input while it runs the bit-serial mean divider (27
//   quotient bits and its done flag), the history memory read, the
//   read-modify-write of the window sums, the classification products
//   and compare, and the load of the result register. Throughput: one
//   sample per cycle inside a scan, stalled as above after each result.
//   A pending result waits in the output register while the next scan
//   streams in; if it is still held when the next scan closes, the block
//   holds in its emit step until the receiver takes it.
//   Registers are written on cfg_valid (cfg_ready is always high); the
//   user must write them only while the block is idle, which the block
//   itself does not enforce. Reset restores register defaults, clears all
//   counters and empties the window; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module lidar_scene_classifier_unit (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsc_pkg::CFG_DAT_W-1:0] cfg_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lsc_pkg::RANGE_W-1:0]   range_mm,
	input  logic                          scan_end,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          indoors,
	output logic                          has_features,
	output logic [1:0]                    density,
	output logic                          changed,
	output logic [lsc_pkg::JMP_W-1:0]     scan_jumps,
	output logic [lsc_pkg::MEAN_W-1:0]    scan_mean_mm
);
	import lsc_pkg::*;

	// Configuration
	logic [RANGE_W-1:0] far_limit_q, dense_in_q, dense_out_q;
	logic [THR_W-1:0]   jump_thr_q;
	logic [PCT_W-1:0]   indoor_pct_q;

	state_t             state_q, state_n;
	logic               in_acc, out_free;
	logic               div_start, div_done;
	logic [MEAN_W-1:0]  mean;
	scan_sum_t          sum;
	win_ctl_t           wctl;
	win_sum_t           wsum;
	hist_t              entry;
	logic               mul_en, prod_en, cls_en, load;

	// Scan snapshot
	logic [SPAN_W-1:0]  span_q;
	logic [JMP_W-1:0]   jumps_q;
	logic [VAL_W-1:0]   valid_q;

	// Classification pipeline
	logic [VCMP_W-1:0]  lhs_s1, rhs_s2;
	logic [IPS_W-1:0]   ips_s1;
	logic [DCMP_W-1:0]  din_s1, dout_s1;
	logic [TCMP_W-1:0]  thr_s1;
	logic [DCMP_W-1:0]  msum_s1;
	logic [TCMP_W-1:0]  jsum_s1;
	logic [CLS_W-1:0]   cls_s3, cls;
	logic               chg_s3;
	logic               cls_indoor, cls_feat;
	dens_t              cls_dens;

	logic [CLS_W-1:0]   last_cls_q;
	logic               cls_valid_q;

	logic               out_valid_q;
	logic               indoors_q, feat_q, chg_q;
	logic [1:0]         dens_q;
	logic [JMP_W-1:0]   jumps_out_q;
	logic [MEAN_W-1:0]  mean_out_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_limit_q  <= RST_FAR_LIMIT;
			jump_thr_q   <= RST_JUMP_THR;
			indoor_pct_q <= RST_INDOOR_PCT;
			dense_in_q   <= RST_DENSE_IN;
			dense_out_q  <= RST_DENSE_OUT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FAR_LIMIT:  far_limit_q  <= cfg_data[RANGE_W-1:0];
				CFG_JUMP_THR:   jump_thr_q   <= cfg_data[THR_W-1:0];
				CFG_INDOOR_PCT: indoor_pct_q <= cfg_data[PCT_W-1:0];
				CFG_DENSE_IN:   dense_in_q   <= cfg_data[RANGE_W-1:0];
				CFG_DENSE_OUT:  dense_out_q  <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	lsc_scan_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.range_mm  (range_mm),
		.scan_end  (scan_end),
		.far_limit (far_limit_q),
		.sum       (sum)
	);

	lsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum.dsum),
		.divisor  (sum.span),
		.done     (div_done),
		.quot     (mean)
	);

	assign entry.jumps = jumps_q;
	assign entry.valid = valid_q;
	assign entry.mean  = mean;

	lsc_window u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wctl),
		.entry  (entry),
		.sums   (wsum)
	);

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (div_start) state_n = ST_DIV;
			ST_DIV:  if (div_done)  state_n = ST_READ;
			ST_READ: state_n = ST_UPD;
			ST_UPD:  state_n = ST_MUL;
			ST_MUL:  state_n = ST_PROD;
			ST_PROD: state_n = ST_CLS;
			ST_CLS:  state_n = ST_EMIT;
			ST_EMIT: if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		div_start = (state_q == ST_IDLE) && in_acc && scan_end && sum.enough;
		wctl.rd   = state_q == ST_READ;
		wctl.wr   = state_q == ST_UPD;
		mul_en    = state_q == ST_MUL;
		prod_en   = state_q == ST_PROD;
		cls_en    = state_q == ST_CLS;
		load      = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			span_q  <= sum.span;
			jumps_q <= sum.jumps;
			valid_q <= sum.valid;
		end
		if (mul_en) begin
			lhs_s1  <= VCMP_W'(wsum.vsum) * VCMP_W'(PCT_SCALE);
			ips_s1  <= IPS_W'(indoor_pct_q) * IPS_W'(wsum.scans);
			din_s1  <= DCMP_W'(dense_in_q) * DCMP_W'(wsum.scans);
			dout_s1 <= DCMP_W'(dense_out_q) * DCMP_W'(wsum.scans);
			thr_s1  <= TCMP_W'(jump_thr_q) * TCMP_W'(wsum.scans);
			msum_s1 <= DCMP_W'(wsum.msum);
			jsum_s1 <= TCMP_W'(wsum.jsum);
		end
		if (prod_en)
			rhs_s2 <= VCMP_W'(ips_s1) * VCMP_W'(span_q);
		if (cls_en) begin
			cls_s3 <= cls;
			chg_s3 <= !cls_valid_q || (cls != last_cls_q);
		end
	end

	// Scene decision from the registered products
	always_comb begin
		if (lhs_s1 <= rhs_s2) begin
			cls_indoor = 1'b0;
			cls_feat   = jsum_s1 != '0;
			cls_dens   = (msum_s1 <= dout_s1) ? DENS_DENSE : DENS_SPARSE;
		end else if (jsum_s1 <= thr_s1) begin
			cls_indoor = 1'b1;
			cls_feat   = 1'b0;
			cls_dens   = DENS_UNKNOWN;
		end else begin
			cls_indoor = 1'b1;
			cls_feat   = 1'b1;
			cls_dens   = (msum_s1 <= din_s1) ? DENS_DENSE : DENS_SPARSE;
		end
		cls = {cls_dens, cls_feat, cls_indoor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cls_q  <= '0;
			cls_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cls_en) begin
				last_cls_q  <= cls;
				cls_valid_q <= 1'b1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			indoors_q   <= cls_s3[0];
			feat_q      <= cls_s3[1];
			dens_q      <= cls_s3[3:2];
			chg_q       <= chg_s3;
			jumps_out_q <= jumps_q;
			mean_out_q  <= mean;
		end
	end

	assign out_valid    = out_valid_q;
	assign indoors      = indoors_q;
	assign has_features = feat_q;
	assign density      = dens_q;
	assign changed      = chg_q;
	assign scan_jumps   = jumps_out_q;
	assign scan_mean_mm = mean_out_q;

endmodule

// File: dv/lidar_scene_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// lidar_scene_classifier_unit_tb
// Streams lidar scans into the classifier and checks every scene result
// against an in-bench scan/window predictor, across several register settings.
// ----------------------------------------------------------------------------
module lidar_scene_classifier_unit_tb;

	import lsc_pkg::*;

	typedef struct packed {
		logic                indoors;
		logic                has_features;
		dens_t               density;
		logic                changed;
		logic [JMP_W-1:0]    jumps;
		logic [MEAN_W-1:0]   mean;
	} scene_result_t;

	typedef struct packed {
		logic [RANGE_W-1:0]  reading;
		logic                last;
		logic                typed;
		scene_result_t       want;
	} stim_row_t;

	typedef enum int {PACE_FLAT, PACE_BUSY, PACE_LIGHT} pace_t;
	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_FAR, STYLE_NEAR} scan_style_t;

	localparam scene_result_t NO_RESULT = '0;
	localparam int FAR_READING   = 65535;
	localparam int MAX_WAIT      = 14;
	localparam int SETTLE_CYCLES = 48;
	localparam int QUIET_LIMIT   = 600;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 84;
	localparam int LONG_SCAN     = MAX_POINTS + 6;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [RANGE_W-1:0]    range_mm;
	logic                  scan_end;
	logic                  out_valid;
	logic                  out_stall;
	logic                  indoors;
	logic                  has_features;
	logic [1:0]            density;
	logic                  changed;
	logic [JMP_W-1:0]      scan_jumps;
	logic [MEAN_W-1:0]     scan_mean_mm;

	lidar_scene_classifier_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.range_mm     (range_mm),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.indoors      (indoors),
		.has_features (has_features),
		.density      (density),
		.changed      (changed),
		.scan_jumps   (scan_jumps),
		.scan_mean_mm (scan_mean_mm)
	);

	always #6 clk = ~clk;

	// Register mirror
	longint unsigned lim_far_limit  = RST_FAR_LIMIT;
	longint unsigned lim_jump_thr   = RST_JUMP_THR;
	longint unsigned lim_indoor_pct = RST_INDOOR_PCT;
	longint unsigned lim_dense_in   = RST_DENSE_IN;
	longint unsigned lim_dense_out  = RST_DENSE_OUT;

	// Scan accumulators and 100-scan window
	logic [RANGE_W-1:0] prior_reading = '0;
	longint unsigned    points = 0, jumps_acc = 0, far_acc = 0, dist_acc = 0;
	longint unsigned    hist_jumps [WINDOW] = '{default: 0};
	longint unsigned    hist_valid [WINDOW] = '{default: 0};
	longint unsigned    hist_mean  [WINDOW] = '{default: 0};
	longint unsigned    win_jumps = 0, win_valid = 0, win_mean = 0;
	int unsigned        slot = 0, seen = 0;
	logic [CLS_W-1:0]   prev_class = '0;
	bit                 class_known = 1'b0;

	scene_result_t pending_scenes [$];
	int            mismatch_count = 0;
	pace_t         send_pace = PACE_BUSY;
	pace_t         recv_pace = PACE_BUSY;
	int            stall_left = 0;
	int            quiet_cycles = 0;

	stim_row_t dir_table [0:22] = '{
		'{16'd1000,  1'b0, 1'b0, NO_RESULT},
		// two equal readings at reset settings: indoors, no features, unknown
		'{16'd1000,  1'b1, 1'b1, '{1'b1, 1'b0, DENS_UNKNOWN, 1'b1, 10'd0, 16'd1000}},
		'{16'd5,     1'b1, 1'b0, NO_RESULT},
		'{16'd0,     1'b0, 1'b0, NO_RESULT},
		// zero to infinite: one jump, one far reading clamped to max range
		'{16'd65535, 1'b1, 1'b1, '{1'b0, 1'b1, DENS_SPARSE, 1'b1, 10'd1, 16'd30000}},
		'{16'd31000, 1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{16'd0,     1'b1, 1'b0, NO_RESULT},
		'{16'd100,   1'b0, 1'b0, NO_RESULT},
		'{16'd135,   1'b0, 1'b0, NO_RESULT},
		'{16'd100,   1'b0, 1'b0, NO_RESULT},
		'{16'd136,   1'b0, 1'b0, NO_RESULT},
		'{16'd100,   1'b0, 1'b0, NO_RESULT},
		'{16'd65,    1'b0, 1'b0, NO_RESULT},
		'{16'd100,   1'b0, 1'b0, NO_RESULT},
		'{16'd64,    1'b1, 1'b0, NO_RESULT},
		'{16'd30000, 1'b0, 1'b0, NO_RESULT},
		'{16'd30001, 1'b1, 1'b0, NO_RESULT},
		'{16'd0,     1'b0, 1'b0, NO_RESULT},
		'{16'd0,     1'b1, 1'b0, NO_RESULT},
		'{16'd65535, 1'b1, 1'b0, NO_RESULT},
		'{16'd65535, 1'b0, 1'b0, NO_RESULT},
		'{16'd65535, 1'b1, 1'b0, NO_RESULT}
	};

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
	                           input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic int draw_wait(input pace_t pace);
		case (pace)
			PACE_FLAT: return 0;
			PACE_BUSY: return $urandom_range(0, MAX_WAIT);
			default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
		endcase
	endfunction

	function automatic void clear_scan_acc();
		prior_reading = '0;
		points = 0;
		jumps_acc = 0;
		far_acc = 0;
		dist_acc = 0;
	endfunction

	function automatic bit classify_sample(input logic [RANGE_W-1:0] reading,
	                                       input logic last, output scene_result_t res);
		longint unsigned r, p, span, valid, mean, s;
		bit              jump, both_far;
		logic            is_indoor, feat;
		dens_t           dens;
		logic [CLS_W-1:0] cls;
		res = NO_RESULT;
		r = reading;
		// readings past the point limit only close the scan
		if (points < MAX_POINTS) begin
			if (points >= 1) begin
				p = prior_reading;
				jump = (JUMP_DEN * r > JUMP_HI_NUM * p) || (JUMP_DEN * r < JUMP_LO_NUM * p);
				both_far = (p > lim_far_limit) && (r > lim_far_limit);
				if (jump && !both_far && jumps_acc < JUMP_MAX)
					jumps_acc++;
				if (r > lim_far_limit) begin
					if (far_acc < FAR_MAX)
						far_acc++;
					dist_acc += lim_far_limit;
				end else begin
					dist_acc += r;
				end
				if (dist_acc > DSUM_MAX)
					dist_acc = DSUM_MAX;
			end
			prior_reading = reading;
			points++;
		end
		if (!last)
			return 1'b0;
		if (points < 2) begin
			clear_scan_acc();
			return 1'b0;
		end
		span = points - 1;
		valid = (far_acc <= span) ? span - far_acc : 0;
		mean = (dist_acc / span) & 64'hFFFF;
		if (slot >= WINDOW)
			slot = 0;
		win_jumps = win_jumps - hist_jumps[slot] + jumps_acc;
		win_valid = win_valid - hist_valid[slot] + valid;
		win_mean  = win_mean - hist_mean[slot] + mean;
		hist_jumps[slot] = jumps_acc;
		hist_valid[slot] = valid;
		hist_mean[slot]  = mean;
		slot++;
		if (slot >= WINDOW)
			slot = 0;
		if (seen < WINDOW)
			seen++;
		s = seen;
		if (PCT_SCALE * win_valid <= lim_indoor_pct * s * span) begin
			is_indoor = 1'b0;
			dens = (win_mean <= lim_dense_out * s) ? DENS_DENSE : DENS_SPARSE;
			feat = (win_jumps != 0);
		end else begin
			is_indoor = 1'b1;
			if (win_jumps <= lim_jump_thr * s) begin
				feat = 1'b0;
				dens = DENS_UNKNOWN;
			end else begin
				feat = 1'b1;
				dens = (win_mean <= lim_dense_in * s) ? DENS_DENSE : DENS_SPARSE;
			end
		end
		cls = {dens, feat, is_indoor};
		res.indoors      = is_indoor;
		res.has_features = feat;
		res.density      = dens;
		res.changed      = !class_known || (cls != prev_class);
		res.jumps        = jumps_acc[JMP_W-1:0];
		res.mean         = mean[MEAN_W-1:0];
		prev_class  = cls;
		class_known = 1'b1;
		clear_scan_acc();
		return 1'b1;
	endfunction

	// Leaves in_valid high; any caller that waits afterwards lowers it first.
	task automatic push_sample(input logic [RANGE_W-1:0] reading, input logic last,
	                           input logic typed = 1'b0, input scene_result_t want = NO_RESULT);
		int            gap;
		scene_result_t res;
		gap = draw_wait(send_pace);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		range_mm <= reading;
		scan_end <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (classify_sample(reading, last, res))
			pending_scenes.push_back(typed ? want : res);
	endtask

	// Hold the input until every pending result is out, then let the block go idle.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_scenes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FAR_LIMIT:  lim_far_limit  = data;
			CFG_JUMP_THR:   lim_jump_thr   = data[THR_W-1:0];
			CFG_INDOOR_PCT: lim_indoor_pct = data[PCT_W-1:0];
			CFG_DENSE_IN:   lim_dense_in   = data;
			CFG_DENSE_OUT:  lim_dense_out  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input int unsigned mr, input int unsigned thr, input int unsigned pct,
	                         input int unsigned din, input int unsigned dout);
		write_reg(CFG_FAR_LIMIT, CFG_DAT_W'(mr));
		write_reg(CFG_JUMP_THR, CFG_DAT_W'(thr));
		write_reg(CFG_INDOOR_PCT, CFG_DAT_W'(pct));
		write_reg(CFG_DENSE_IN, CFG_DAT_W'(din));
		write_reg(CFG_DENSE_OUT, CFG_DAT_W'(dout));
	endtask

	task automatic apply_phase(input int ph);
		logic [CFG_DAT_W-1:0] junk;
		case (ph)
			1: write_all(0, 0, 0, 0, 0);
			2: write_all(65534, 1023, 100, 65535, 65535);
			3, 5: write_all($urandom_range(0, 65534), $urandom_range(0, 1023),
			                $urandom_range(0, 100), $urandom_range(0, 65535),
			                $urandom_range(0, 65535));
			4: begin
				// upper data bits must be dropped; unused indexes must do nothing
				junk = CFG_DAT_W'($urandom);
				write_reg(CFG_JUMP_THR, {junk[15:10], 10'($urandom_range(0, 1023))});
				junk = CFG_DAT_W'($urandom);
				write_reg(CFG_INDOOR_PCT, {junk[15:7], 7'($urandom_range(0, 100))});
				write_reg(CFG_FAR_LIMIT, CFG_DAT_W'($urandom_range(1000, 40000)));
				for (int k = int'(CFG_DENSE_OUT) + 1; k < (1 << CFG_IDX_W); k++)
					write_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom));
			end
			6: write_all($urandom_range(500, 3000), $urandom_range(0, 20), $urandom_range(30, 95),
			             $urandom_range(0, 3000), $urandom_range(0, 3000));
			7: write_all(RST_FAR_LIMIT, RST_JUMP_THR, RST_INDOOR_PCT, RST_DENSE_IN, RST_DENSE_OUT);
			default: ;
		endcase
	endtask

	function automatic logic [RANGE_W-1:0] pick_reading(input scan_style_t style,
	                                                    input logic [RANGE_W-1:0] prev);
		int v, step;
		case (style)
			STYLE_SMOOTH: begin
				step = $urandom_range(0, prev / 4 + 8);
				v = $urandom_range(0, 1) ? int'(prev) + step : int'(prev) - step;
			end
			STYLE_FAR: v = $urandom_range(0, 1) ? FAR_READING
			                                    : int'(lim_far_limit) - 2 + $urandom_range(0, 4);
			STYLE_NEAR: v = $urandom_range(0, 8000);
			default: v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > FAR_READING)
			v = FAR_READING;
		return v[RANGE_W-1:0];
	endfunction

	task automatic run_scan(input int len);
		scan_style_t      style;
		logic [RANGE_W-1:0] cur;
		style = scan_style_t'($urandom_range(0, 3));
		send_pace = pace_t'($urandom_range(0, 2));
		recv_pace = pace_t'($urandom_range(0, 2));
		cur = RANGE_W'($urandom_range(0, 65535));
		for (int i = 0; i < len; i++) begin
			cur = ($urandom_range(0, 15) == 0) ? pick_reading(STYLE_NOISE, cur)
			                                   : pick_reading(style, cur);
			push_sample(cur, i == len - 1);
		end
	endtask

	// Result side: check each taken transaction, then stall the next one for a drawn number of cycles once it shows.
	always @(posedge clk) begin
		scene_result_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_scenes.size() == 0) begin
				report_mismatch("result transaction with nothing pending");
			end else begin
				want = pending_scenes.pop_front();
				check_field("indoors", indoors, want.indoors);
				check_field("has_features", has_features, want.has_features);
				check_field("density", density, want.density);
				check_field("changed", changed, want.changed);
				check_field("scan_jumps", scan_jumps, want.jumps);
				check_field("scan_mean_mm", scan_mean_mm, want.mean);
			end
			stall_left = draw_wait(recv_pace);
			out_stall <= (stall_left != 0);
		end else if (out_valid === 1'b1 && stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
			    (cfg_valid && cfg_ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("lidar_scene_classifier_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int phase_items;
		int len, k;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FAR_LIMIT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		range_mm  = '0;
		scan_end  = 1'b0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			push_sample(dir_table[i].reading, dir_table[i].last, dir_table[i].typed,
			            dir_table[i].want);

		// overlong alternating scan: every counted step is a jump, tail is dropped
		send_pace = PACE_LIGHT;
		for (int i = 0; i < LONG_SCAN; i++)
			push_sample((i % 2) ? 16'd2000 : 16'd1000, i == LONG_SCAN - 1);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			apply_phase(ph);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				k = $urandom_range(0, 29);
				if (k < 3)
					len = 1;
				else if (k < 6)
					len = 2;
				else if (k == 29)
					len = $urandom_range(40, 120);
				else
					len = $urandom_range(3, 16);
				run_scan(len);
				phase_items += len;
				if ($urandom_range(0, 24) == 0)
					settle();
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("lidar_scene_classifier_unit regression: pass");
		else
			$display("lidar_scene_classifier_unit regression: fail");
		$finish;
	end

endmodule
